>>> rtl/bfa_pkg.sv
// shared types, constants and helpers of the bitmap frame allocator
package bfa_pkg;

   // defaults of the top-level parameters
   localparam int MAX_FRAMES_DEFAULT = 256;
   localparam int MAX_BATCH_DEFAULT  = 64;

   // one map word holds the free bits of eight consecutive frames
   localparam int WORD_BITS = 8;
   localparam int BIT_W     = 3;

   // fixed field widths
   localparam int CSR_W      = 9;
   localparam int COUNT_W    = 7;
   localparam int FRAME_W    = 8;
   localparam int FREE_CNT_W = 9;

   // stream payload widths
   localparam int REQ_DATA_W = 16;
   localparam int REQ_USER_W = 1;
   localparam int RSP_DATA_W = 24;
   localparam int RSP_USER_W = 3;

   // request kinds
   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   // result status codes
   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_NO_SPACE = 2'd1;
   localparam logic [1:0] STATUS_BAD_FREE = 2'd2;

   // controller to datapath
   typedef struct packed {
      logic       init_start;   // reload free total, rewind map address
      logic       init_write;   // write one initial map word, step address
      logic       accept;       // capture the request fields
      logic       rd_en;        // read a map word
      logic       rd_next;      // read at the following word address
      logic       load_word;    // take the read word as the working word
      logic       grant;        // hand out the lowest free frame of the working word
      logic       grant_wb;     // write the cleared working word back
      logic       skip_word;    // write back the empty working word, step address
      logic       single;       // produce a lone result
      logic [1:0] single_code;  // its status
      logic       free_commit;  // set the released frame's bit
   } bfa_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic init_last;
      logic is_free;
      logic count_zero;
      logic count_bad;
      logic word_empty;
      logic last_grant;
      logic free_bad;
      logic out_ready;
   } bfa_stat_type;

   // index of the lowest set bit of a map word
   function automatic logic [BIT_W-1:0] lowest_set(input logic [WORD_BITS-1:0] word);
      logic [BIT_W-1:0] idx;
      idx = '0;
      for (int b = WORD_BITS - 1; b >= 0; b--) begin
         if (word[b]) begin
            idx = BIT_W'(b);
         end
      end
      return idx;
   endfunction

endpackage

>>> rtl/bfa_ctrl.sv
// controller state machine of the bitmap frame allocator
module bfa_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_we,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  bfa_pkg::bfa_stat_type stat,
   output bfa_pkg::bfa_cmd_type  cmd
);
   import bfa_pkg::*;

   localparam logic [2:0] S_INIT_START = 3'd0;
   localparam logic [2:0] S_INIT       = 3'd1;
   localparam logic [2:0] S_IDLE       = 3'd2;
   localparam logic [2:0] S_DECIDE     = 3'd3;
   localparam logic [2:0] S_LOAD       = 3'd4;
   localparam logic [2:0] S_SCAN       = 3'd5;
   localparam logic [2:0] S_FREE_CHK   = 3'd6;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      cmd        = '0;
      state_in   = state_ff;
      req_tready = 1'b0;
      unique case (state_ff)
         S_INIT_START: begin
            cmd.init_start = 1'b1;
            state_in       = S_INIT;
         end
         S_INIT: begin
            cmd.init_write = 1'b1;
            if (stat.init_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_tready = !csr_we;
            if (req_tvalid && !csr_we) begin
               cmd.accept = 1'b1;
               state_in   = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (stat.is_free) begin
               cmd.rd_en = 1'b1;
               state_in  = S_FREE_CHK;
            end else if (stat.count_zero || stat.count_bad) begin
               if (stat.out_ready) begin
                  cmd.single      = 1'b1;
                  cmd.single_code = stat.count_zero ? STATUS_OK : STATUS_NO_SPACE;
                  state_in        = S_IDLE;
               end
            end else begin
               cmd.rd_en = 1'b1;
               state_in  = S_LOAD;
            end
         end
         S_LOAD: begin
            cmd.load_word = 1'b1;
            state_in      = S_SCAN;
         end
         S_SCAN: begin
            if (stat.word_empty) begin
               cmd.skip_word = 1'b1;
               cmd.rd_en     = 1'b1;
               cmd.rd_next   = 1'b1;
               state_in      = S_LOAD;
            end else if (stat.out_ready) begin
               cmd.grant = 1'b1;
               if (stat.last_grant) begin
                  cmd.grant_wb = 1'b1;
                  state_in     = S_IDLE;
               end
            end
         end
         S_FREE_CHK: begin
            if (stat.out_ready) begin
               cmd.single      = 1'b1;
               cmd.single_code = stat.free_bad ? STATUS_BAD_FREE : STATUS_OK;
               cmd.free_commit = !stat.free_bad;
               state_in        = S_IDLE;
            end
         end
         default: begin
            state_in = S_INIT_START;
         end
      endcase
      if (csr_we) begin
         state_in = S_INIT_START;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT_START;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> rtl/bfa_datapath.sv
// datapath of the bitmap frame allocator: free map memory, counters, result register
module bfa_datapath #(
   parameter int MAX_FRAMES = bfa_pkg::MAX_FRAMES_DEFAULT,
   parameter int MAX_BATCH  = bfa_pkg::MAX_BATCH_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [bfa_pkg::CSR_W-1:0]       csr_wdata,
   input  logic [bfa_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  logic [bfa_pkg::REQ_USER_W-1:0]  req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [bfa_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic [bfa_pkg::RSP_USER_W-1:0]  rsp_tuser,
   output logic                            rsp_tlast,
   input  bfa_pkg::bfa_cmd_type            cmd,
   output bfa_pkg::bfa_stat_type           stat
);
   import bfa_pkg::*;

   localparam int DEPTH   = (MAX_FRAMES + WORD_BITS - 1) / WORD_BITS;
   localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int TOTAL_W = $clog2(MAX_FRAMES + 1);

   // free map, one bit per frame
   logic [WORD_BITS-1:0] map_mem [DEPTH];

   logic [TOTAL_W-1:0]   num_frames_ff;
   logic [TOTAL_W-1:0]   free_total_ff, free_total_in;
   logic [ADDR_W-1:0]    addr_ff, addr_in;
   logic [COUNT_W-1:0]   rem_ff;
   logic                 op_ff;
   logic [COUNT_W-1:0]   count_ff;
   logic [FRAME_W-1:0]   fin_ff;
   logic [WORD_BITS-1:0] cur_word_ff;
   logic [WORD_BITS-1:0] rd_data_ff;

   logic                  rsp_valid_ff;
   logic [FRAME_W-1:0]    rsp_frame_ff;
   logic                  rsp_fvalid_ff;
   logic [1:0]            rsp_status_ff;
   logic                  rsp_last_ff;
   logic [FREE_CNT_W-1:0] rsp_free_ff;

   logic [TOTAL_W-1:0]   csr_sat;
   logic [WORD_BITS-1:0] init_word;
   logic [BIT_W-1:0]     grant_bit;
   logic [WORD_BITS-1:0] grant_mask;
   logic [WORD_BITS-1:0] cleared_word;
   logic [WORD_BITS-1:0] free_mask;
   logic                 wr_en;
   logic [WORD_BITS-1:0] wr_data;
   logic [ADDR_W-1:0]    rd_addr;
   logic                 out_ready;
   logic                 rsp_load;

   // register value saturated into 1..MAX_FRAMES
   always_comb begin
      if (csr_wdata == '0) begin
         csr_sat = TOTAL_W'(1);
      end else if (32'(csr_wdata) > 32'(MAX_FRAMES)) begin
         csr_sat = TOTAL_W'(MAX_FRAMES);
      end else begin
         csr_sat = TOTAL_W'(csr_wdata);
      end
   end

   always_comb begin
      for (int b = 0; b < WORD_BITS; b++) begin
         init_word[b] = 32'({addr_ff, BIT_W'(b)}) < 32'(num_frames_ff);
      end
   end

   assign grant_bit    = lowest_set(cur_word_ff);
   assign grant_mask   = WORD_BITS'(1) << grant_bit;
   assign cleared_word = cur_word_ff & ~grant_mask;
   assign free_mask    = WORD_BITS'(1) << fin_ff[BIT_W-1:0];
   assign out_ready    = !rsp_valid_ff || rsp_tready;
   assign rsp_load     = cmd.grant || cmd.single;

   assign stat.init_last  = addr_ff == ADDR_W'(DEPTH - 1);
   assign stat.is_free    = op_ff == CMD_FREE;
   assign stat.count_zero = count_ff == '0;
   assign stat.count_bad  = (32'(count_ff) > 32'(MAX_BATCH)) ||
                            (32'(count_ff) > 32'(free_total_ff));
   assign stat.word_empty = cur_word_ff == '0;
   assign stat.last_grant = rem_ff == COUNT_W'(1);
   assign stat.free_bad   = (32'(fin_ff) >= 32'(num_frames_ff)) ||
                            ((rd_data_ff & free_mask) != '0);
   assign stat.out_ready  = out_ready;

   assign wr_en   = cmd.init_write || cmd.skip_word || cmd.grant_wb || cmd.free_commit;
   assign rd_addr = cmd.rd_next ? ADDR_W'(addr_ff + 1'b1) : addr_ff;

   always_comb begin
      priority if (cmd.init_write) begin
         wr_data = init_word;
      end else if (cmd.skip_word) begin
         wr_data = cur_word_ff;
      end else if (cmd.grant_wb) begin
         wr_data = cleared_word;
      end else begin
         wr_data = rd_data_ff | free_mask;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         map_mem[addr_ff] <= wr_data;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= map_mem[rd_addr];
      end
   end

   always_comb begin
      addr_in = addr_ff;
      if (cmd.init_start) begin
         addr_in = '0;
      end else if (cmd.init_write || cmd.skip_word) begin
         addr_in = ADDR_W'(addr_ff + 1'b1);
      end else if (cmd.accept) begin
         addr_in = (req_tuser[0] == CMD_FREE) ?
                   ADDR_W'(req_tdata[COUNT_W+FRAME_W-1:COUNT_W+BIT_W]) : '0;
      end
   end

   always_comb begin
      free_total_in = free_total_ff;
      if (cmd.init_start) begin
         free_total_in = num_frames_ff;
      end else if (cmd.grant) begin
         free_total_in = free_total_ff - 1'b1;
      end else if (cmd.free_commit) begin
         free_total_in = free_total_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_frames_ff <= TOTAL_W'(MAX_FRAMES);
         free_total_ff <= TOTAL_W'(MAX_FRAMES);
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_we) begin
            num_frames_ff <= csr_sat;
         end
         free_total_ff <= free_total_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      addr_ff <= addr_in;
      if (cmd.accept) begin
         op_ff    <= req_tuser[0];
         count_ff <= req_tdata[COUNT_W-1:0];
         fin_ff   <= req_tdata[COUNT_W+FRAME_W-1:COUNT_W];
         rem_ff   <= req_tdata[COUNT_W-1:0];
      end else if (cmd.grant) begin
         rem_ff <= rem_ff - 1'b1;
      end
      if (cmd.load_word) begin
         cur_word_ff <= rd_data_ff;
      end else if (cmd.grant) begin
         cur_word_ff <= cleared_word;
      end
      if (cmd.grant) begin
         rsp_frame_ff  <= FRAME_W'({addr_ff, grant_bit});
         rsp_fvalid_ff <= 1'b1;
         rsp_status_ff <= STATUS_OK;
         rsp_last_ff   <= stat.last_grant;
         rsp_free_ff   <= FREE_CNT_W'(free_total_in);
      end else if (cmd.single) begin
         rsp_frame_ff  <= '0;
         rsp_fvalid_ff <= 1'b0;
         rsp_status_ff <= cmd.single_code;
         rsp_last_ff   <= 1'b1;
         rsp_free_ff   <= FREE_CNT_W'(free_total_in);
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_DATA_W - FRAME_W - FREE_CNT_W)'(0), rsp_free_ff, rsp_frame_ff};
   assign rsp_tuser  = {rsp_status_ff, rsp_fvalid_ff};
   assign rsp_tlast  = rsp_last_ff;

`ifndef SYNTHESIS
   a_total_bound: assert property (@(posedge clock) disable iff (reset)
      !cmd.init_start |-> (free_total_ff <= num_frames_ff))
      else $error("free total exceeds managed frames");

   a_grant_ok: assert property (@(posedge clock) disable iff (reset)
      cmd.grant |-> ((cur_word_ff != '0) && out_ready))
      else $error("grant from empty word or into a full result register");

   a_grant_count: assert property (@(posedge clock) disable iff (reset)
      cmd.grant |=> (free_total_ff == $past(free_total_ff) - 1'b1))
      else $error("free total not decremented on grant");

   a_grant_last: assert property (@(posedge clock) disable iff (reset)
      (cmd.grant && stat.last_grant) |=> (rsp_valid_ff && rsp_last_ff))
      else $error("final grant not marked last");
`endif

endmodule

>>> rtl/bitmap_frame_allocator.sv
// top level of the bitmap page-frame allocator
// Hands out page frames from a free map of one bit per frame, kept in an on-chip memory of
// eight-frame words, with a running free-frame count. A free item (tuser 1) goes through one
// map read and one check, then the result is loaded. An allocate item (tuser 0) asking for N
// frames is first decided, then walks the map word by word from frame 0, reading and
// inspecting each word visited and granting the frames it finds; zero-frame and refused
// requests end with a lone result after the decision. A request is finished before the
// next is taken. The single memory port and the word-at-a-time priority search set the
// pace of the walk. After reset and after every write of num_frames the map is rebuilt by
// a sweep over all ceil(MAX_FRAMES/8) map words during which no request is taken. Results
// go through an output register; back-pressure on the result side holds the sequencer
// whenever it has a result to load, which also stalls the request side.
module bitmap_frame_allocator #(
   parameter int MAX_FRAMES = bfa_pkg::MAX_FRAMES_DEFAULT,  // frames in the map
   parameter int MAX_BATCH  = bfa_pkg::MAX_BATCH_DEFAULT    // largest allocate request
) (
   input  logic                            clock,
   input  logic                            reset,
   // num_frames register
   input  logic                            csr_we,
   input  logic [bfa_pkg::CSR_W-1:0]       csr_wdata,
   // request stream
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [bfa_pkg::REQ_DATA_W-1:0]  req_tdata,   // alloc_count[6:0], frame_number_in[14:7]
   input  logic [bfa_pkg::REQ_USER_W-1:0]  req_tuser,   // cmd[0]
   // result stream
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [bfa_pkg::RSP_DATA_W-1:0]  rsp_tdata,   // frame_number[7:0], free_count[16:8]
   output logic [bfa_pkg::RSP_USER_W-1:0]  rsp_tuser,   // frame_valid[0], status[2:1]
   output logic                            rsp_tlast    // last result of the request
);
   import bfa_pkg::*;

   // command and status between sequencer and datapath
   bfa_cmd_type  cmd;
   bfa_stat_type stat;

   // sequencer: init sweep, request decode, word-by-word search
   bfa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   // map memory, counters and the result register
   bfa_datapath #(
      .MAX_FRAMES (MAX_FRAMES),
      .MAX_BATCH  (MAX_BATCH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .cmd        (cmd),
      .stat       (stat)
   );

endmodule

>>> verif/bitmap_frame_allocator_test.sv
// self-checking testbench for the bitmap frame allocator: random stimulus with a free-map model
module bitmap_frame_allocator_test;
   import bfa_pkg::*;

   localparam int FRAMES = MAX_FRAMES_DEFAULT;
   localparam int BATCH  = MAX_BATCH_DEFAULT;

   // one request transfer, fields as the block sees them
   typedef struct packed {
      logic               cmd;
      logic [COUNT_W-1:0] count;
      logic [FRAME_W-1:0] frame;
   } frame_req_type;

   // one result transfer
   typedef struct {
      logic [FRAME_W-1:0]    frame;
      logic                  granted;
      logic [1:0]            status;
      logic                  is_last;
      logic [FREE_CNT_W-1:0] free_cnt;
   } frame_rsp_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_we = 1'b0;
   logic [CSR_W-1:0]      csr_wdata = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;   // alloc_count[6:0], frame_number_in[14:7]
   logic [REQ_USER_W-1:0] req_tuser = '0;   // cmd[0]
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;        // frame_number[7:0], free_count[16:8]
   logic [RSP_USER_W-1:0] rsp_tuser;        // frame_valid[0], status[2:1]
   logic                  rsp_tlast;

   bitmap_frame_allocator #(
      .MAX_FRAMES(FRAMES),
      .MAX_BATCH (BATCH)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .rsp_tlast (rsp_tlast)
   );

   // shadow of the allocator: free bit per frame, free total, managed frame count
   logic                  frame_free [FRAMES];
   logic [FREE_CNT_W-1:0] free_left;
   int                    frame_limit;

   frame_req_type request_q[$];   // requests waiting for the driver
   frame_rsp_type outcome_q[$];   // results predicted but not yet seen

   int req_issued   = 0;       // requests put on the bus
   int req_accepted = 0;       // request transfers completed
   int mismatches   = 0;
   int idle_pct     = 0;       // chance per cycle of starting an idle burst, both sides
   int req_gap      = 0;
   int rsp_hold     = 0;
   bit long_hold_pending = 1'b0;

   initial begin
      forever #4 clock = ~clock;
   end

   // watchdog: far beyond the slowest legal run
   initial begin
      #8000000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // rebuild the shadow map as the block does after reset or a frame-count write
   task automatic restore_map();
      for (int i = 0; i < FRAMES; i++) begin
         frame_free[i] = (i < frame_limit);
      end
      free_left = FREE_CNT_W'(frame_limit);
   endtask

   function automatic frame_rsp_type lone_result(input logic [1:0] status);
      frame_rsp_type o;
      o.frame    = '0;
      o.granted  = 1'b0;
      o.status   = status;
      o.is_last  = 1'b1;
      o.free_cnt = free_left;
      return o;
   endfunction

   // append one predicted result at the tail of the pending list
   task automatic expect_result(input frame_rsp_type o);
      outcome_q.insert(outcome_q.size(), o);
   endtask

   // apply one accepted request to the shadow map and queue the results it causes
   task automatic compute_allocation(input frame_req_type r);
      frame_rsp_type o;
      int            handed;
      handed = 0;
      if (r.cmd == CMD_FREE) begin
         // out of range or already free: refused, nothing changes
         if (r.frame >= frame_limit || frame_free[r.frame]) begin
            expect_result(lone_result(STATUS_BAD_FREE));
         end else begin
            frame_free[r.frame] = 1'b1;
            free_left++;
            expect_result(lone_result(STATUS_OK));
         end
      end else if (r.count == 0) begin
         expect_result(lone_result(STATUS_OK));
      end else if (r.count > BATCH || r.count > free_left) begin
         expect_result(lone_result(STATUS_NO_SPACE));
      end else begin
         // lowest-numbered free frames first, ascending
         for (int i = 0; i < FRAMES && handed < r.count; i++) begin
            if (frame_free[i]) begin
               frame_free[i] = 1'b0;
               free_left--;
               handed++;
               o.frame    = FRAME_W'(i);
               o.granted  = 1'b1;
               o.status   = STATUS_OK;
               o.is_last  = (handed == r.count);
               o.free_cnt = free_left;
               expect_result(o);
            end
         end
      end
   endtask

   function automatic void check_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endfunction

   // monitor: results are checked before the same edge's request is predicted
   always @(posedge clock) begin : monitor
      frame_rsp_type want;
      frame_req_type taken;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (outcome_q.size() == 0) begin
               $error("result transfer with no result pending: frame %0d status %0d",
                      rsp_tdata[7:0], rsp_tuser[2:1]);
               mismatches++;
            end else begin
               want = outcome_q.pop_front();
               check_field("frame_number", want.frame, rsp_tdata[7:0]);
               check_field("frame_valid", want.granted, rsp_tuser[0]);
               check_field("status", want.status, rsp_tuser[2:1]);
               check_field("last", want.is_last, rsp_tlast);
               check_field("free_count", want.free_cnt, rsp_tdata[16:8]);
            end
         end
         if (req_tvalid && req_tready) begin
            taken.cmd   = req_tuser[0];
            taken.count = req_tdata[6:0];
            taken.frame = req_tdata[14:7];
            compute_allocation(taken);
            req_accepted++;
         end
      end
   end

   // request driver: a new item only once the previous one has transferred
   always @(negedge clock) begin : driver
      frame_req_type next_req;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (req_accepted == req_issued) begin
         if (req_gap > 0) begin
            req_gap--;
            req_tvalid <= 1'b0;
         end else if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
            // start an idle burst
            req_gap = $urandom_range(0, 13);
            req_tvalid <= 1'b0;
         end else if (request_q.size() != 0) begin
            next_req = request_q.pop_front();
            req_tuser  <= next_req.cmd;
            req_tdata  <= REQ_DATA_W'({next_req.frame, next_req.count});
            req_tvalid <= 1'b1;
            req_issued++;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // result side back-pressure: random bursts plus one long hold on request
   always @(negedge clock) begin : receiver
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (rsp_hold > 0) begin
         rsp_hold--;
         rsp_tready <= 1'b0;
      end else if (long_hold_pending) begin
         // long enough for the output register to fill and the request side to stall
         long_hold_pending = 1'b0;
         rsp_hold = 399;
         rsp_tready <= 1'b0;
      end else if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
         rsp_hold = $urandom_range(0, 13);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   task automatic push_req(input logic cmd, input int count, input int frame);
      frame_req_type r;
      r.cmd   = cmd;
      r.count = COUNT_W'(count);
      r.frame = FRAME_W'(frame);
      request_q.insert(request_q.size(), r);
   endtask

   // mostly small allocations and frees of likely-used low frames, some wide noise
   task automatic queue_random(input int n);
      int pick;
      int sub;
      int hi;
      for (int k = 0; k < n; k++) begin
         pick = $urandom_range(0, 99);
         sub  = $urandom_range(0, 99);
         hi   = (frame_limit > 80) ? 80 : frame_limit - 1;
         if (pick < 50) begin
            if (sub < 60)      push_req(CMD_ALLOC, $urandom_range(1, 4), $urandom_range(0, 255));
            else if (sub < 80) push_req(CMD_ALLOC, $urandom_range(5, 16), $urandom_range(0, 255));
            else if (sub < 88) push_req(CMD_ALLOC, $urandom_range(17, BATCH),
                                        $urandom_range(0, 255));
            else if (sub < 94) push_req(CMD_ALLOC, 0, $urandom_range(0, 255));
            else               push_req(CMD_ALLOC, $urandom_range(BATCH + 1, 127),
                                        $urandom_range(0, 255));
         end else if (pick < 90) begin
            push_req(CMD_FREE, $urandom_range(0, 127), $urandom_range(0, hi));
         end else begin
            // any frame, in range or not
            push_req(CMD_FREE, $urandom_range(0, 127), $urandom_range(0, 255));
         end
      end
   endtask

   // wait until everything sent has transferred and every result has come back
   task automatic drain();
      while (request_q.size() != 0 || req_issued != req_accepted || outcome_q.size() != 0) begin
         @(posedge clock);
      end
      repeat (4) @(negedge clock);
   endtask

   // frame-count write; the block saturates into 1..FRAMES and rebuilds its map
   task automatic write_frame_limit(input int value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= CSR_W'(value);
      @(negedge clock);
      csr_we    <= 1'b0;
      frame_limit = (value < 1) ? 1 : (value > FRAMES) ? FRAMES : value;
      restore_map();
   endtask

   initial begin : stimulus
      frame_limit = FRAMES;
      restore_map();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: full map of 256 frames
      idle_pct = 15;
      push_req(CMD_ALLOC, 0, 0);          // zero-frame request
      push_req(CMD_ALLOC, 127, 255);      // above batch limit, all count bits set
      push_req(CMD_ALLOC, BATCH + 1, 0);
      push_req(CMD_ALLOC, BATCH, 0);      // frames 0..63
      push_req(CMD_FREE, 0, 5);
      push_req(CMD_FREE, 0, 5);           // already free
      push_req(CMD_FREE, 127, 255);       // never allocated
      push_req(CMD_FREE, 0, 0);
      push_req(CMD_FREE, 0, 63);
      push_req(CMD_ALLOC, 3, 0);          // refills the holes 0, 5, 63
      push_req(CMD_ALLOC, BATCH, 0);
      push_req(CMD_ALLOC, BATCH, 0);
      push_req(CMD_ALLOC, BATCH, 0);      // map now full
      push_req(CMD_ALLOC, 1, 0);          // not enough free frames
      push_req(CMD_FREE, 0, 255);
      push_req(CMD_FREE, 0, 128);
      push_req(CMD_ALLOC, 2, 0);
      push_req(CMD_FREE, 0, 200);
      push_req(CMD_ALLOC, 1, 0);
      drain();

      // sender keeps offering while the result side holds off
      idle_pct = 25;
      queue_random(40);
      long_hold_pending = 1'b1;
      drain();

      // directed: single-frame map (a write of zero saturates up to one)
      write_frame_limit(0);
      push_req(CMD_ALLOC, 1, 0);
      push_req(CMD_ALLOC, 1, 0);
      push_req(CMD_FREE, 0, 1);           // out of range
      push_req(CMD_FREE, 0, 0);
      push_req(CMD_FREE, 0, 0);
      push_req(CMD_ALLOC, 2, 0);          // more than the map holds
      drain();

      write_frame_limit(37);
      idle_pct = 10;
      queue_random(25);
      drain();
      idle_pct = 0;                       // stretch without idling
      queue_random(25);
      drain();

      write_frame_limit(8);
      idle_pct = 30;
      queue_random(30);
      drain();

      // all nine bits set, saturates down to the full map
      write_frame_limit(511);
      idle_pct = 15;
      queue_random(35);
      drain();

      write_frame_limit(1);
      queue_random(15);
      drain();

      write_frame_limit(5);
      idle_pct = 20;
      queue_random(15);
      drain();

      // last part runs flat out
      write_frame_limit(FRAMES);
      idle_pct = 0;
      queue_random(15);
      drain();

      repeat (20) @(posedge clock);
      if (mismatches == 0 && outcome_q.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

>>> files.f
rtl/bfa_pkg.sv
rtl/bfa_ctrl.sv
rtl/bfa_datapath.sv
rtl/bitmap_frame_allocator.sv
verif/bitmap_frame_allocator_test.sv
